[hw/rtl/tlv_stream_deframer_macros.svh]
// assertion macros shared by the deframer checker
`ifndef TLV_STREAM_DEFRAMER_MACROS_SVH
`define TLV_STREAM_DEFRAMER_MACROS_SVH

// same-cycle implication, off while reset is low
`define TLVD_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off while reset is low
`define TLVD_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/tlvd_pkg.sv]
// shared types and constants for the tlv stream deframer
package tlvd_pkg;

    localparam int DATA_W          = 8;
    localparam int CFG_W           = 32;
    localparam int ACC_W           = 24;
    localparam int USER_W          = 10;
    localparam int LENGTH_BITS_DEF = 32;

    localparam logic [CFG_W-1:0]  MAX_LENGTH_RST = 32'd65536;

    // accepted message types
    localparam logic [DATA_W-1:0] TYPE_ONE     = 8'd1;
    localparam logic [DATA_W-1:0] TYPE_TWO     = 8'd2;
    localparam logic [DATA_W-1:0] TYPE_HUNDRED = 8'd100;

    // result status codes
    typedef enum logic [1:0] {
        ST_BODY    = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_BADTYPE = 2'd2,
        ST_TOOBIG  = 2'd3
    } status_t;

    // parser phases, one-hot
    typedef enum logic [6:0] {
        PH_TYPE = 7'b0000001,
        PH_LEN0 = 7'b0000010,
        PH_LEN1 = 7'b0000100,
        PH_LEN2 = 7'b0001000,
        PH_LEN3 = 7'b0010000,
        PH_BODY = 7'b0100000,
        PH_DEAD = 7'b1000000
    } phase_t;

    // one result item plus its valid flag
    typedef struct packed {
        logic              valid;
        status_t           status;
        logic [DATA_W-1:0] body_byte;
        logic [DATA_W-1:0] msg_type;
        logic              last;
    } res_t;

endpackage

[hw/rtl/tlvd_parser.sv]
// header and body parser: state registers plus per-byte decode
module tlvd_parser import tlvd_pkg::*; #(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    input  logic [DATA_W-1:0] in_byte,
    input  logic              advance,
    input  logic [CFG_W-1:0]  max_length,
    output res_t              res
);

    localparam logic [CFG_W-1:0] LEN_LIMIT =
        CFG_W'((33'd1 << LENGTH_BITS) - 33'd1);

    phase_t                  phase_reg, phase_next;
    logic [DATA_W-1:0]       type_hold_reg, type_hold_next;
    logic [ACC_W-1:0]        acc_reg, acc_next;
    logic [LENGTH_BITS-1:0]  left_reg, left_next;
    logic [LENGTH_BITS-1:0]  left_dec;
    logic [CFG_W-1:0]        len_full;
    logic                    type_ok;
    res_t                    res_raw;

    assign len_full = {acc_reg, in_byte};
    assign left_dec = left_reg - LENGTH_BITS'(1);
    assign type_ok  = type_hold_reg inside {TYPE_ONE, TYPE_TWO, TYPE_HUNDRED};

    // per-byte decode
    always_comb begin
        phase_next       = phase_reg;
        type_hold_next   = type_hold_reg;
        acc_next         = acc_reg;
        left_next        = left_reg;
        res_raw          = '0;
        res_raw.msg_type = type_hold_reg;
        case (phase_reg)
            PH_TYPE: begin
                type_hold_next = in_byte;
                acc_next       = '0;
                phase_next     = PH_LEN0;
            end
            PH_LEN0: begin
                acc_next   = {acc_reg[ACC_W-DATA_W-1:0], in_byte};
                phase_next = PH_LEN1;
            end
            PH_LEN1: begin
                acc_next   = {acc_reg[ACC_W-DATA_W-1:0], in_byte};
                phase_next = PH_LEN2;
            end
            PH_LEN2: begin
                acc_next   = {acc_reg[ACC_W-DATA_W-1:0], in_byte};
                phase_next = PH_LEN3;
            end
            PH_LEN3: begin
                // type check wins over length check
                if (!type_ok) begin
                    phase_next     = PH_DEAD;
                    res_raw.valid  = 1'b1;
                    res_raw.status = ST_BADTYPE;
                end else if (len_full > max_length || len_full > LEN_LIMIT) begin
                    phase_next     = PH_DEAD;
                    res_raw.valid  = 1'b1;
                    res_raw.status = ST_TOOBIG;
                end else if (len_full == '0) begin
                    phase_next     = PH_TYPE;
                    res_raw.valid  = 1'b1;
                    res_raw.status = ST_EMPTY;
                    res_raw.last   = 1'b1;
                end else begin
                    left_next  = len_full[LENGTH_BITS-1:0];
                    phase_next = PH_BODY;
                end
            end
            PH_BODY: begin
                left_next         = left_dec;
                res_raw.valid     = 1'b1;
                res_raw.status    = ST_BODY;
                res_raw.body_byte = in_byte;
                res_raw.last      = (left_dec == '0);
                if (left_dec == '0) begin
                    phase_next = PH_TYPE;
                end
            end
            PH_DEAD: begin
                phase_next = PH_DEAD;
            end
            default: begin
                phase_next = PH_DEAD;
            end
        endcase
    end

    // result only when a byte is present
    always_comb begin
        res       = res_raw;
        res.valid = res_raw.valid & in_valid;
    end

    // phase register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_TYPE;
        end else if (advance) begin
            phase_reg <= phase_next;
        end
    end

    // header and count registers
    always_ff @(posedge aclk) begin
        if (advance) begin
            type_hold_reg <= type_hold_next;
            acc_reg       <= acc_next;
            left_reg      <= left_next;
        end
    end

endmodule

[hw/rtl/tlvd_out_reg.sv]
// result register on the master side
module tlvd_out_reg import tlvd_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  res_t  in_res,
    output logic  in_ready,
    output res_t  out_res,
    input  logic  out_ready
);

    logic valid_reg;
    res_t data_reg;

    assign in_ready      = !valid_reg || out_ready;

    // held result, its valid bit taken from the flag register
    always_comb begin
        out_res       = data_reg;
        out_res.valid = valid_reg;
    end

    // valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_res.valid;
        end
    end

    // payload, loaded when the slot frees up
    always_ff @(posedge aclk) begin
        if (in_ready && in_res.valid) begin
            data_reg <= in_res;
        end
    end

endmodule

[hw/rtl/tlv_stream_deframer.sv]
// top level of the tlv stream deframer
// a byte is held in the input register, decoded by the parser and its result
// held in the result register; throughput: one byte per cycle unless the
// result port stalls, set by the input register feeding the parser and the
// result register behind it; reset: aresetn low clears valids, returns to
// the type byte, restores max_length to 65536 and ends an error's dead state
module tlv_stream_deframer import tlvd_pkg::*; #(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    // configuration: max_length
    input  logic              cfg_wen,
    input  logic [CFG_W-1:0]  cfg_wdata,
    // input request
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [DATA_W-1:0] s_tdata,   // [7:0] data_byte
    // result request
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [DATA_W-1:0] m_tdata,   // [7:0] body_byte
    output logic [USER_W-1:0] m_tuser,   // [1:0] status, [9:2] msg_type
    output logic              m_tlast
);

    logic              in_valid_reg;
    logic [DATA_W-1:0] in_byte_reg;
    logic [CFG_W-1:0]  max_length_reg;
    logic              advance;
    logic              out_in_ready;
    res_t              par_res;
    res_t              out_res;

    // a held byte moves on if it makes no result or the result slot is free
    assign advance  = in_valid_reg && (!par_res.valid || out_in_ready);
    assign s_tready = !in_valid_reg || advance;

    // max_length register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_length_reg <= MAX_LENGTH_RST;
        end else if (cfg_wen) begin
            max_length_reg <= cfg_wdata;
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
        end
    end

    tlvd_parser #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (in_valid_reg),
        .in_byte    (in_byte_reg),
        .advance    (advance),
        .max_length (max_length_reg),
        .res        (par_res)
    );

    tlvd_out_reg u_out_reg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_res    (par_res),
        .in_ready  (out_in_ready),
        .out_res   (out_res),
        .out_ready (m_tready)
    );

    // result port packing
    assign m_tvalid = out_res.valid;
    assign m_tdata  = out_res.body_byte;
    assign m_tuser  = {out_res.msg_type, out_res.status};
    assign m_tlast  = out_res.last;

endmodule

[hw/rtl/tlvd_checker.sv]
// port-level checker for the tlv stream deframer, bound to the top level
`include "tlv_stream_deframer_macros.svh"

module tlvd_checker import tlvd_pkg::*; (
    input logic              aclk,
    input logic              aresetn,
    input logic              m_tvalid,
    input logic              m_tready,
    input logic [DATA_W-1:0] m_tdata,
    input logic [USER_W-1:0] m_tuser,
    input logic              m_tlast
);

    // stalled result holds
    `TLVD_ASSERT_NXT(a_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "stalled result changed")

    // only body results carry a data byte
    `TLVD_ASSERT_IMP(a_zero_body, aclk, aresetn, m_tvalid && m_tuser[1:0] != ST_BODY, m_tdata == '0, "non-body result with data")

    // empty message is last, errors are not
    `TLVD_ASSERT_IMP(a_last_kind, aclk, aresetn, m_tvalid && m_tuser[1:0] != ST_BODY, m_tlast == (m_tuser[1:0] == ST_EMPTY), "wrong last flag")

    // bad type error names a type outside the accepted set
    `TLVD_ASSERT_IMP(a_bad_type, aclk, aresetn, m_tvalid && m_tuser[1:0] == ST_BADTYPE, m_tuser[9:2] != TYPE_ONE && m_tuser[9:2] != TYPE_TWO && m_tuser[9:2] != TYPE_HUNDRED, "bad type error on good type")

endmodule

bind tlv_stream_deframer tlvd_checker u_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

[tb/tlv_stream_deframer_checker.sv]
// checker for the tlv stream deframer: predicts each result and compares it
module tlv_stream_deframer_checker import tlvd_pkg::*; #(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wen,
    input  logic [CFG_W-1:0]  cfg_wdata,
    input  logic              s_tvalid,
    input  logic              s_tready,
    input  logic [DATA_W-1:0] s_tdata,   // [7:0] data_byte
    input  logic              m_tvalid,
    input  logic              m_tready,
    input  logic [DATA_W-1:0] m_tdata,   // [7:0] body_byte
    input  logic [USER_W-1:0] m_tuser,   // [1:0] status, [9:2] msg_type
    input  logic              m_tlast,
    output int                fail_count,
    output int                pending,
    output int                result_count
);

    localparam logic [32:0] LEN_CAP = (33'd1 << LENGTH_BITS) - 33'd1;

    typedef struct packed {
        status_t           status;
        logic [DATA_W-1:0] body_byte;
        logic [DATA_W-1:0] msg_type;
        logic              last;
    } deframed_t;

    // results still owed by the block, oldest first
    deframed_t         due_results[$];

    // parser copy
    phase_t            phase;
    logic [DATA_W-1:0] type_hold;
    logic [31:0]       length_accum;
    logic [31:0]       bytes_left;
    logic [CFG_W-1:0]  max_length;

    function automatic logic type_known(input logic [DATA_W-1:0] t);
        return t == TYPE_ONE || t == TYPE_TWO || t == TYPE_HUNDRED;
    endfunction

    // append one owed result at the young end
    function automatic void owe_result(input deframed_t r);
        due_results = {due_results, r};
    endfunction

    // advance the parser by one byte, queue the result it owes
    task automatic deframe_byte(input logic [DATA_W-1:0] b);
        logic [31:0] len_next;
        len_next = {length_accum[23:0], b};
        case (phase)
            PH_TYPE: begin
                type_hold    = b;
                length_accum = '0;
                phase        = PH_LEN0;
            end
            PH_LEN0: begin
                length_accum = len_next;
                phase        = PH_LEN1;
            end
            PH_LEN1: begin
                length_accum = len_next;
                phase        = PH_LEN2;
            end
            PH_LEN2: begin
                length_accum = len_next;
                phase        = PH_LEN3;
            end
            PH_LEN3: begin
                // type is checked ahead of the length
                length_accum = len_next;
                if (!type_known(type_hold)) begin
                    phase = PH_DEAD;
                    owe_result('{ST_BADTYPE, 8'h00, type_hold, 1'b0});
                end else if (len_next > max_length || {1'b0, len_next} > LEN_CAP) begin
                    phase = PH_DEAD;
                    owe_result('{ST_TOOBIG, 8'h00, type_hold, 1'b0});
                end else if (len_next == 32'd0) begin
                    phase = PH_TYPE;
                    owe_result('{ST_EMPTY, 8'h00, type_hold, 1'b1});
                end else begin
                    bytes_left = len_next;
                    phase      = PH_BODY;
                end
            end
            PH_BODY: begin
                bytes_left = bytes_left - 32'd1;
                owe_result('{ST_BODY, b, type_hold, bytes_left == 32'd0});
                if (bytes_left == 32'd0) begin
                    phase = PH_TYPE;
                end
            end
            default: begin
                phase = PH_DEAD;
            end
        endcase
    endtask

    function automatic void compare_field(input string name, input logic [7:0] want,
                                          input logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    // compare one accepted result with the oldest one owed
    task automatic check_result();
        deframed_t want;
        result_count++;
        if (due_results.size() == 0) begin
            $error("result with none owed: tuser %h tdata %h tlast %b",
                   m_tuser, m_tdata, m_tlast);
            fail_count++;
        end else begin
            want = due_results.pop_front();
            compare_field("status", 8'(want.status), 8'(m_tuser[1:0]));
            compare_field("msg_type", want.msg_type, m_tuser[9:2]);
            compare_field("body_byte", want.body_byte, m_tdata);
            compare_field("last", 8'(want.last), 8'(m_tlast));
        end
    endtask

    // watch both requests and the register port at each edge
    always @(posedge aclk) begin
        if (!aresetn) begin
            phase        = PH_TYPE;
            type_hold    = '0;
            length_accum = '0;
            bytes_left   = '0;
            max_length   = MAX_LENGTH_RST;
            due_results.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                check_result();
            end
            if (cfg_wen) begin
                max_length = cfg_wdata;
            end
            if (s_tvalid && s_tready) begin
                deframe_byte(s_tdata);
            end
        end
        pending = due_results.size();
    end

endmodule

[tb/tlv_stream_deframer_tb.sv]
// testbench top for the tlv stream deframer: stimulus, flow control and verdict
module tlv_stream_deframer_tb import tlvd_pkg::*; ();

    localparam int RESULT_LAT = 4;

    typedef enum int {
        FATAL_TYPE,
        FATAL_LENGTH,
        FATAL_BOTH
    } fatal_t;

    logic              aclk = 1'b0;
    logic              aresetn;
    logic              cfg_wen;
    logic [CFG_W-1:0]  cfg_wdata;
    logic              s_tvalid;
    logic              s_tready;
    logic [DATA_W-1:0] s_tdata;   // [7:0] data_byte
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [DATA_W-1:0] m_tdata;   // [7:0] body_byte
    logic [USER_W-1:0] m_tuser;   // [1:0] status, [9:2] msg_type
    logic              m_tlast;

    int                fail_count;
    int                pending;
    int                result_count;
    int                s_idle_pct  = 15;
    int                r_stall_pct = 70;
    int                bytes_sent  = 0;
    int                msgs_sent   = 0;
    logic [CFG_W-1:0]  cur_max;

    tlv_stream_deframer dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    tlv_stream_deframer_checker chk (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wen      (cfg_wen),
        .cfg_wdata    (cfg_wdata),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .m_tlast      (m_tlast),
        .fail_count   (fail_count),
        .pending      (pending),
        .result_count (result_count)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // receiver stalls at random
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= r_stall_pct);
    end

    function automatic logic [7:0] pick_type();
        case ($urandom_range(2))
            0:       return TYPE_ONE;
            1:       return TYPE_TWO;
            default: return TYPE_HUNDRED;
        endcase
    endfunction

    // one byte request, with random gaps in front of it
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < s_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        bytes_sent++;
    endtask

    task automatic send_header(input logic [7:0] mtype, input logic [31:0] len);
        send_byte(mtype);
        for (int i = 3; i >= 0; i--) begin
            send_byte(len[8*i +: 8]);
        end
    endtask

    // fill below zero means random body bytes
    task automatic send_msg(input logic [7:0] mtype, input logic [31:0] len, input int fill);
        send_header(mtype, len);
        for (int unsigned i = 0; i < len; i++) begin
            send_byte((fill < 0) ? 8'($urandom_range(255)) : 8'(fill));
        end
        msgs_sent++;
    endtask

    // mostly short bodies, a few long ones, never above the limit
    task automatic rand_msg();
        int unsigned cap;
        int unsigned roll;
        roll = $urandom_range(99);
        cap  = (cur_max < 300) ? cur_max : 300;
        if (roll < 70) begin
            cap = (cap < 8) ? cap : 8;
        end else if (roll < 95) begin
            cap = (cap < 40) ? cap : 40;
        end
        send_msg(pick_type(), $urandom_range(cap), -1);
    endtask

    // hold the sender until every owed result is out and the pipe is empty
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (RESULT_LAT) @(negedge aclk);
    endtask

    task automatic write_max(input logic [CFG_W-1:0] v);
        cfg_wen   <= 1'b1;
        cfg_wdata <= v;
        @(negedge aclk);
        cfg_wen   <= 1'b0;
        cur_max    = v;
    endtask

    initial begin
        fatal_t      kind;
        logic [7:0]  bad_type;
        logic [31:0] bad_len;
        aresetn   = 1'b0;
        cfg_wen   = 1'b0;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cur_max   = MAX_LENGTH_RST;
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: empty messages and body bytes at both extremes
        send_msg(TYPE_ONE, 0, -1);
        send_msg(TYPE_HUNDRED, 0, -1);
        send_msg(TYPE_TWO, 2, 8'hff);
        send_msg(TYPE_ONE, 1, 8'h00);
        drain();

        // zero limit lets only empty messages through
        write_max('0);
        for (int i = 0; i < 9; i++) begin
            send_msg(pick_type(), 0, -1);
        end
        drain();

        // small limit, body exactly at the limit first
        write_max(5);
        send_msg(TYPE_HUNDRED, 5, -1);
        while (bytes_sent < 250) rand_msg();

        // stop inside a header, raise the limit, then finish the message
        send_byte(TYPE_TWO);
        send_byte(8'h00);
        send_byte(8'h00);
        send_byte(8'h00);
        drain();
        write_max(300);
        send_byte(8'd200);
        for (int i = 0; i < 200; i++) begin
            send_byte(8'($urandom_range(255)));
        end
        msgs_sent++;

        // now the sender idles more than the receiver
        s_idle_pct  = 70;
        r_stall_pct = 15;
        while (bytes_sent < 600) rand_msg();
        drain();
        while (bytes_sent < 800) rand_msg();
        drain();

        // largest limit, no idling from here on
        write_max('1);
        s_idle_pct  = 0;
        r_stall_pct = 0;
        while (bytes_sent < 1150) rand_msg();
        drain();

        write_max($urandom_range(64, 1));
        while (bytes_sent < 1400) rand_msg();

        // one fatal header, then bytes the dead parser must swallow
        kind     = fatal_t'($urandom_range(2));
        bad_type = pick_type();
        bad_len  = ($urandom_range(1) != 0) ? cur_max + 1
                                            : $urandom_range(32'hffff_ffff, cur_max + 1);
        if (kind != FATAL_LENGTH) begin
            do bad_type = 8'($urandom_range(255));
            while (bad_type == TYPE_ONE || bad_type == TYPE_TWO || bad_type == TYPE_HUNDRED);
        end
        if (kind == FATAL_TYPE) begin
            bad_len = $urandom_range(cur_max);
        end
        send_header(bad_type, bad_len);
        msgs_sent++;
        repeat (12) send_byte(8'($urandom_range(255)));
        drain();
        repeat (10) @(negedge aclk);

        $display("sent %0d bytes in %0d messages under six length limits, last one %0d",
                 bytes_sent, msgs_sent, cur_max);
        $display("checked %0d results, stream closed by a %s header", result_count,
                 kind.name());
        if (fail_count == 0 && pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // watchdog
    initial begin
        #(20 * 400000);
        $display("timed out with %0d results still owed", pending);
        $display("== FAIL ==");
        $finish;
    end

endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/tlvd_pkg.sv
hw/rtl/tlvd_parser.sv
hw/rtl/tlvd_out_reg.sv
hw/rtl/tlv_stream_deframer.sv
hw/rtl/tlvd_checker.sv
tb/tlv_stream_deframer_checker.sv
tb/tlv_stream_deframer_tb.sv
